// ===== hw/rtl/tsps_pkg.sv =====
// Package for the transport stream sync search block.
// Holds status codes, fixed widths, constants and the structs shared between modules.
// No dependencies.
`default_nettype none

package tsps_pkg;

  localparam int SHORT_PACKET = 188;
  localparam int LONG_PACKET  = 204;

  localparam int BYTE_W   = 8;
  localparam int OFFSET_W = 16;
  localparam int SEEN_W   = 17;

  localparam logic [BYTE_W-1:0]   SYNC_BYTE        = 8'h47;
  localparam logic [SEEN_W-1:0]   SEEN_MAX         = 17'h1FFFF;
  localparam logic [OFFSET_W-1:0] MAX_OFFSET_RESET = 16'd19787;

  typedef enum logic [1:0] {
    STATUS_SHORT = 2'd0,
    STATUS_LONG  = 2'd1,
    STATUS_NONE  = 2'd2
  } status_t;

  // Registered input transaction, byte already reduced to a sync flag
  typedef struct packed {
    logic valid;
    logic is_sync;
    logic eow;
  } stage_t;

  // Tap test results of the flag delay line
  typedef struct packed {
    logic short_hit;
    logic long_hit;
  } taps_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tsps_in_if.sv =====
// Input channel of the sync search: one window byte per transaction.
// Depends on tsps_pkg.
`default_nettype none

interface tsps_in_if;
  logic                        valid;
  logic                        ready;
  logic [tsps_pkg::BYTE_W-1:0] data_byte;
  logic                        end_of_window;

  modport source (output valid, output data_byte, output end_of_window, input ready);
  modport sink   (input valid, input data_byte, input end_of_window, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/tsps_out_if.sv =====
// Result channel of the sync search: packet length code and sync offset.
// Depends on tsps_pkg.
`default_nettype none

interface tsps_out_if;
  logic                          valid;
  logic                          ready;
  tsps_pkg::status_t             sync_status;
  logic [tsps_pkg::OFFSET_W-1:0] sync_offset;

  modport source (output valid, output sync_status, output sync_offset, input ready);
  modport sink   (input valid, input sync_status, input sync_offset, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/tsps_in_stage.sv =====
// Input register of the sync search: captures a byte transaction and flags 0x47.
// Depends on tsps_pkg.
`default_nettype none

module tsps_in_stage (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        valid,
  output logic                             ready,
  input  wire logic [tsps_pkg::BYTE_W-1:0] data_byte,
  input  wire logic                        end_of_window,
  input  wire logic                        advance,
  output tsps_pkg::stage_t                 stage
);

  assign ready = !stage.valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
    end else if (ready) begin
      stage.valid <= valid;
    end
    if (valid && ready) begin
      stage.is_sync <= (data_byte == tsps_pkg::SYNC_BYTE);
      stage.eow     <= end_of_window;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tsps_sync_line.sv =====
// Delay line of sync flags, one bit per stored byte, with the 188 and 204 tap tests.
// Depends on tsps_pkg.
`default_nettype none

module tsps_sync_line #(
  parameter int SYNC_MATCHES = 5
) (
  input  wire logic clk,
  input  wire logic shift_en,
  input  wire logic is_sync,
  output tsps_pkg::taps_t taps
);

  localparam int HistDepth = (SYNC_MATCHES - 1) * tsps_pkg::LONG_PACKET + 1;

  logic [HistDepth-1:0] line;
  logic [HistDepth-1:0] line_next;
  logic [SYNC_MATCHES-1:0] short_taps;
  logic [SYNC_MATCHES-1:0] long_taps;

  // bit 0 is the newest byte; the candidate is the oldest one
  assign line_next = {line[HistDepth-2:0], is_sync};

  for (genvar k = 0; k < SYNC_MATCHES; k++) begin : g_tap
    assign short_taps[k] = line_next[HistDepth-1-k*tsps_pkg::SHORT_PACKET];
    assign long_taps[k]  = line_next[HistDepth-1-k*tsps_pkg::LONG_PACKET];
  end

  assign taps.short_hit = &short_taps;
  assign taps.long_hit  = &long_taps;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      line <= line_next;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/tsps_search_core.sv =====
// Window control of the sync search: byte count, candidate range check and result register.
// Depends on tsps_pkg; drives the shift of tsps_sync_line.
`default_nettype none

module tsps_search_core #(
  parameter int SYNC_MATCHES = 5
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire tsps_pkg::stage_t              stage,
  input  wire tsps_pkg::taps_t               taps,
  input  wire logic [tsps_pkg::OFFSET_W-1:0] max_offset,
  input  wire logic                          out_ready,
  output logic                               advance,
  output logic                               shift_en,
  output logic                               out_valid,
  output tsps_pkg::status_t                  out_status,
  output logic [tsps_pkg::OFFSET_W-1:0]      out_offset
);

  localparam int HistDepth = (SYNC_MATCHES - 1) * tsps_pkg::LONG_PACKET + 1;
  localparam logic [tsps_pkg::SEEN_W-1:0] HistDepthW = tsps_pkg::SEEN_W'(HistDepth);

  logic [tsps_pkg::SEEN_W-1:0] seen;
  logic [tsps_pkg::SEEN_W-1:0] seen_next;
  logic                        done;
  logic                        done_next;
  logic [tsps_pkg::SEEN_W-1:0] seen_inc;
  logic [tsps_pkg::SEEN_W-1:0] cand;
  logic                        process;
  logic                        in_range;
  logic                        hit_short;
  logic                        hit_long;
  logic                        emit;
  tsps_pkg::status_t           status_next;

  assign advance  = !out_valid || out_ready;
  assign process  = stage.valid && advance;
  assign shift_en = process && !done && (seen != tsps_pkg::SEEN_MAX);

  assign seen_inc = seen + 1'b1;
  assign cand     = seen_inc - HistDepthW;
  assign in_range = (seen_inc >= HistDepthW) && ({1'b0, max_offset} >= cand);

  assign hit_short = shift_en && in_range && taps.short_hit;
  assign hit_long  = shift_en && in_range && !taps.short_hit && taps.long_hit;

  always_comb begin
    seen_next   = seen;
    done_next   = done;
    emit        = 1'b0;
    status_next = tsps_pkg::STATUS_NONE;
    if (shift_en) begin
      seen_next = seen_inc;
    end
    if (hit_short || hit_long) begin
      done_next   = 1'b1;
      emit        = 1'b1;
      status_next = hit_short ? tsps_pkg::STATUS_SHORT : tsps_pkg::STATUS_LONG;
    end
    if (process && stage.eow) begin
      // not_found only if nothing hit in this window
      if (!done_next) begin
        emit        = 1'b1;
        status_next = tsps_pkg::STATUS_NONE;
      end
      seen_next = '0;
      done_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen      <= '0;
      done      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      seen <= seen_next;
      done <= done_next;
      if (advance) begin
        out_valid <= emit;
      end
    end
    if (advance && emit) begin
      out_status <= status_next;
      out_offset <= (status_next == tsps_pkg::STATUS_NONE) ? '0 : cand[tsps_pkg::OFFSET_W-1:0];
    end
  end

  a_eow_rearms: assert property (@(posedge clk) disable iff (rst)
    process && stage.eow |=> (seen == '0) && !done)
    else $error("window end did not rearm the search");

  a_hit_sets_done: assert property (@(posedge clk) disable iff (rst)
    (hit_short || hit_long) && !stage.eow |=> done)
    else $error("hit did not stop the search");

  a_ignore_after_hit: assert property (@(posedge clk) disable iff (rst)
    done && !(process && stage.eow) |=> $stable(seen))
    else $error("byte counted after a hit");

  a_none_zero_offset: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_status == tsps_pkg::STATUS_NONE) |-> out_offset == '0)
    else $error("not_found result carries an offset");

endmodule

`default_nettype wire

// ===== hw/rtl/ts_packet_sync_search.sv =====
// Transport stream sync search: top level wiring of input stage, flag line and window control.
// Depends on tsps_pkg, tsps_in_if, tsps_out_if, tsps_in_stage, tsps_sync_line, tsps_search_core.
//
// Finds the packet length (188 or 204) and the offset of the first sync byte
// in a search window of bytes. One byte is taken every clock; there is no
// stall of its own, only back-pressure from the result channel. A byte passes
// the input register and then the result register on its way to the result
// it causes. A candidate offset is tested once the (SYNC_MATCHES-1)*204+1
// bytes starting at it have arrived (817 by default), against 0x47 flags kept
// in a one-bit delay line. The first hit gives one result and the rest of the
// window is dropped; a window end without a hit gives not_found. Offsets
// above max_offset are not tested. Write max_offset only while idle.
`default_nettype none

module ts_packet_sync_search #(
  parameter int SYNC_MATCHES = 5
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  tsps_in_if.sink                            byte_in,
  tsps_out_if.source                         result_out,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [tsps_pkg::OFFSET_W-1:0] cfg_data
);

  logic [tsps_pkg::OFFSET_W-1:0] max_offset;
  tsps_pkg::stage_t              stage;
  tsps_pkg::taps_t               taps;
  logic                          advance;
  logic                          shift_en;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_offset <= tsps_pkg::MAX_OFFSET_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_offset <= cfg_data;
    end
  end

  tsps_in_stage u_in_stage (
    .clk           (clk),
    .rst           (rst),
    .valid         (byte_in.valid),
    .ready         (byte_in.ready),
    .data_byte     (byte_in.data_byte),
    .end_of_window (byte_in.end_of_window),
    .advance       (advance),
    .stage         (stage)
  );

  tsps_sync_line #(
    .SYNC_MATCHES (SYNC_MATCHES)
  ) u_sync_line (
    .clk      (clk),
    .shift_en (shift_en),
    .is_sync  (stage.is_sync),
    .taps     (taps)
  );

  tsps_search_core #(
    .SYNC_MATCHES (SYNC_MATCHES)
  ) u_search_core (
    .clk        (clk),
    .rst        (rst),
    .stage      (stage),
    .taps       (taps),
    .max_offset (max_offset),
    .out_ready  (result_out.ready),
    .advance    (advance),
    .shift_en   (shift_en),
    .out_valid  (result_out.valid),
    .out_status (result_out.sync_status),
    .out_offset (result_out.sync_offset)
  );

endmodule

`default_nettype wire

// ===== test/tsps_sync_checker.sv =====
`timescale 1ns / 100ps
// Result checker for ts_packet_sync_search: follows the byte, result and register channels.
// Predicts each sync result from the accepted bytes and compares it field by field.
// Depends on tsps_pkg, tsps_in_if and tsps_out_if.

module tsps_sync_checker
  import tsps_pkg::*;
#(
  parameter int SYNC_MATCHES = 5
) (
  input  wire logic                clk,
  input  wire logic                rst,
  tsps_in_if                       byte_mon,
  tsps_out_if                      result_mon,
  input  wire logic                cfg_valid,
  input  wire logic                cfg_ready,
  input  wire logic [OFFSET_W-1:0] cfg_data,
  output int                       mismatches,
  output int                       pending,
  output int                       windows,
  output int                       short_hits,
  output int                       long_hits,
  output int                       misses,
  output int                       bytes_in,
  output int                       cfg_writes
);

  localparam int HIST_DEPTH = (SYNC_MATCHES - 1) * LONG_PACKET + 1;

  typedef struct packed {
    status_t             status;
    logic [OFFSET_W-1:0] offset;
  } sync_result_t;

  sync_result_t        sync_expect_q[$];
  logic [BYTE_W-1:0]   history[HIST_DEPTH];
  logic [SEEN_W-1:0]   seen_cnt;
  logic                found;
  logic [OFFSET_W-1:0] offset_limit;
  int                  result_idx;

  function automatic bit sync_taps(int start, int spacing);
    int pos;
    for (int k = 0; k < SYNC_MATCHES; k++) begin
      pos = (start + k * spacing) % HIST_DEPTH;
      if (history[pos] != SYNC_BYTE) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic push_sync(status_t status, logic [OFFSET_W-1:0] offset);
    sync_result_t res;
    res.status = status;
    res.offset = offset;
    sync_expect_q.push_back(res);
  endtask

  task automatic predict_sync(input logic [BYTE_W-1:0] b, input logic eow);
    int cand;
    if (!found && seen_cnt < SEEN_MAX) begin
      history[seen_cnt % HIST_DEPTH] = b;
      seen_cnt++;
      if (seen_cnt >= HIST_DEPTH) begin
        // oldest byte of the line is the candidate start
        cand = int'(seen_cnt) - HIST_DEPTH;
        if (cand <= int'(offset_limit)) begin
          if (sync_taps(cand % HIST_DEPTH, SHORT_PACKET)) begin
            push_sync(STATUS_SHORT, cand[OFFSET_W-1:0]);
            found = 1'b1;
            short_hits++;
          end else if (sync_taps(cand % HIST_DEPTH, LONG_PACKET)) begin
            push_sync(STATUS_LONG, cand[OFFSET_W-1:0]);
            found = 1'b1;
            long_hits++;
          end
        end
      end
    end
    if (eow) begin
      if (!found) begin
        push_sync(STATUS_NONE, '0);
        misses++;
      end
      seen_cnt = '0;
      found    = 1'b0;
      windows++;
    end
  endtask

  task automatic report_mismatch(input string what);
    $display("[%0t] sync result %0d: %s", $time, result_idx, what);
    mismatches++;
  endtask

  task automatic check_result();
    sync_result_t exp_res;
    if (sync_expect_q.size() == 0) begin
      report_mismatch($sformatf("unexpected transaction status %0d offset %0d",
                                result_mon.sync_status, result_mon.sync_offset));
    end else begin
      exp_res = sync_expect_q.pop_front();
      if (result_mon.sync_status !== exp_res.status)
        report_mismatch($sformatf("status %0d, expected %0d",
                                  result_mon.sync_status, exp_res.status));
      if (result_mon.sync_offset !== exp_res.offset)
        report_mismatch($sformatf("offset %0d, expected %0d",
                                  result_mon.sync_offset, exp_res.offset));
    end
    result_idx++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      seen_cnt     = '0;
      found        = 1'b0;
      offset_limit = MAX_OFFSET_RESET;
      sync_expect_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        offset_limit = cfg_data;
        cfg_writes++;
      end
      if (byte_mon.valid && byte_mon.ready) begin
        predict_sync(byte_mon.data_byte, byte_mon.end_of_window);
        bytes_in++;
      end
      if (result_mon.valid && result_mon.ready) check_result();
    end
    pending = sync_expect_q.size();
  end

endmodule

// ===== test/tb_ts_packet_sync_search.sv =====
`timescale 1ns / 100ps
// Testbench top for ts_packet_sync_search: clock, reset, byte windows, result stalls, verdict.
// Depends on tsps_pkg, tsps_in_if, tsps_out_if, the block and tsps_sync_checker.

module tb_ts_packet_sync_search;
  import tsps_pkg::*;

  localparam int MATCHES      = 5;
  localparam int HIST         = (MATCHES - 1) * LONG_PACKET + 1;
  localparam int CLK_HIGH     = 6;
  localparam int CLK_LOW      = 6;
  localparam int LIMIT_CYCLES = 20_000_000;
  localparam int IDLE_GUARD   = 4;
  localparam int DRAIN_CYCLES = 16;
  localparam int RAND_WINDOWS = 48;
  localparam int RAND_BYTES   = 800;

  logic                clk;
  logic                rst;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [OFFSET_W-1:0] cfg_data;

  int mismatches, pending, windows, short_hits, long_hits, misses, bytes_in, cfg_writes;
  int cycles;
  int burst_left;

  logic [BYTE_W-1:0] window_bytes[$];

  tsps_in_if  byte_ch();
  tsps_out_if result_ch();

  ts_packet_sync_search #(.SYNC_MATCHES(MATCHES)) DUT (
    .clk       (clk),
    .rst       (rst),
    .byte_in   (byte_ch),
    .result_out(result_ch),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  tsps_sync_checker #(.SYNC_MATCHES(MATCHES)) sync_chk (
    .clk       (clk),
    .rst       (rst),
    .byte_mon  (byte_ch),
    .result_mon(result_ch),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .mismatches(mismatches),
    .pending   (pending),
    .windows   (windows),
    .short_hits(short_hits),
    .long_hits (long_hits),
    .misses    (misses),
    .bytes_in  (bytes_in),
    .cfg_writes(cfg_writes)
  );

  always begin
    clk = 1'b0;
    #(CLK_LOW);
    clk = 1'b1;
    #(CLK_HIGH);
  end

  initial cycles = 0;

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("ts_packet_sync_search: mismatch");
      $finish;
    end
  end

  // result side stall pattern from a 16-bit ready mask, reshuffled at random
  initial begin : result_stalls
    int               step;
    logic [15:0]      mask;
    result_ch.ready = 1'b0;
    mask = '1;
    step = 0;
    forever begin
      @(negedge clk);
      if (step % 32 == 0) begin
        case ($urandom_range(0, 3))
          0:       mask = '1;
          1:       mask = 16'($urandom);
          2:       mask = 16'($urandom) & 16'($urandom) & 16'($urandom);
          default: mask = 16'($urandom) | 16'($urandom);
        endcase
      end
      result_ch.ready <= mask[step % 16];
      step++;
    end
  end

  // one transaction; valid stays high within a burst and may drop between bursts
  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic eow);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 3);
      burst_left = $urandom_range(1, 64);
      if (gap > 0) begin
        byte_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    byte_ch.valid         <= 1'b1;
    byte_ch.data_byte     <= b;
    byte_ch.end_of_window <= eow;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic fill_window(int len, int sync_pct);
    window_bytes.delete();
    for (int i = 0; i < len; i++)
      window_bytes.push_back(($urandom_range(0, 99) < sync_pct) ? SYNC_BYTE : 8'($urandom));
  endtask

  task automatic plant_taps(int start, int spacing);
    int pos;
    for (int k = 0; k < MATCHES; k++) begin
      pos = start + k * spacing;
      if (pos < window_bytes.size()) window_bytes[pos] = SYNC_BYTE;
    end
  endtask

  task automatic send_window();
    for (int i = 0; i < window_bytes.size(); i++)
      send_byte(window_bytes[i], i == window_bytes.size() - 1);
  endtask

  task automatic sync_window(int len, int sync_pct, int start, int spacing);
    fill_window(len, sync_pct);
    if (start >= 0) plant_taps(start, spacing);
    send_window();
  endtask

  // register write only once the block has drained
  task automatic write_max_offset(logic [OFFSET_W-1:0] value);
    byte_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (IDLE_GUARD) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_window();
    int kind, len, start, start2, spacing, k;
    kind    = $urandom_range(0, 99);
    spacing = $urandom_range(0, 1) ? SHORT_PACKET : LONG_PACKET;
    start   = $urandom_range(0, 260);
    if (kind < 50) begin
      // well formed, sometimes cut short before the candidate is complete
      if ($urandom_range(0, 4) == 0) len = start + HIST - $urandom_range(1, 80);
      else len = start + HIST + $urandom_range(0, 150);
      sync_window(len, 1, start, spacing);
    end else if (kind < 65) begin
      start2 = $urandom_range(0, 200);
      len    = ((start > start2) ? start : start2) + HIST + $urandom_range(0, 60);
      fill_window(len, 1);
      plant_taps(start, LONG_PACKET);
      plant_taps(start2, SHORT_PACKET);
      send_window();
    end else if (kind < 80) begin
      // one tap spoiled, maybe a good run a little later
      len = start + HIST + $urandom_range(0, 120);
      fill_window(len, 1);
      plant_taps(start, spacing);
      k = $urandom_range(0, MATCHES - 1);
      window_bytes[start + k * spacing] = SYNC_BYTE ^ 8'($urandom_range(1, 255));
      if ($urandom_range(0, 1)) plant_taps(start + $urandom_range(1, 40), spacing);
      send_window();
    end else if (kind < 90) begin
      sync_window(HIST + $urandom_range(0, 100), 60, -1, 0);
    end else begin
      sync_window($urandom_range(1, HIST - 1), 30, -1, 0);
    end
  endtask

  initial begin : stimulus
    int rnd_windows, first_byte;
    byte_ch.valid         = 1'b0;
    byte_ch.data_byte     = '0;
    byte_ch.end_of_window = 1'b0;
    cfg_valid             = 1'b0;
    cfg_data              = '0;
    burst_left            = 0;
    rst                   = 1'b1;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // short windows: single byte, and one byte short of a full line
    sync_window(1, 100, -1, 0);
    sync_window(HIST - 1, 0, 0, SHORT_PACKET);
    // hit on the last byte of the window
    sync_window(HIST, 0, 0, SHORT_PACKET);
    // 204 hit, rest of the window dropped
    sync_window(900, 0, 3, LONG_PACKET);
    // both spacings at one candidate: 188 wins
    fill_window(1000, 0);
    plant_taps(10, LONG_PACKET);
    plant_taps(10, SHORT_PACKET);
    send_window();
    // data extremes
    window_bytes.delete();
    for (int i = 0; i < 850; i++) window_bytes.push_back((i % 2) ? 8'hFF : 8'h00);
    send_window();
    sync_window(HIST, 100, -1, 0);
    // just past the reset offset limit
    sync_window(int'(MAX_OFFSET_RESET) + 1 + HIST + 5, 0, int'(MAX_OFFSET_RESET) + 1,
                LONG_PACKET);

    write_max_offset(16'd0);
    sync_window(HIST, 0, 0, SHORT_PACKET);
    sync_window(900, 0, 1, SHORT_PACKET);
    write_max_offset(16'd5);
    sync_window(HIST + 20, 0, 5, LONG_PACKET);
    sync_window(HIST + 20, 0, 6, LONG_PACKET);
    write_max_offset(16'hFFFF);
    sync_window(65535 + HIST + 10, 0, 65535, SHORT_PACKET);
    // byte counter runs into saturation
    sync_window(131100, 0, -1, 0);
    write_max_offset(MAX_OFFSET_RESET);

    rnd_windows = 0;
    first_byte  = bytes_in;
    while (rnd_windows < RAND_WINDOWS || bytes_in - first_byte < RAND_BYTES) begin
      if (rnd_windows % 8 == 0) begin
        case ($urandom_range(0, 5))
          0:       write_max_offset(16'd0);
          1:       write_max_offset(16'hFFFF);
          2:       write_max_offset(16'($urandom_range(1, 260)));
          3:       write_max_offset(MAX_OFFSET_RESET);
          default: write_max_offset(16'($urandom));
        endcase
      end
      random_window();
      rnd_windows++;
    end
    byte_ch.valid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("covered %0d windows, %0d bytes, %0d max_offset writes incl. 0 and 65535",
             windows, bytes_in, cfg_writes);
    $display("results: %0d at 188 bytes, %0d at 204 bytes, %0d without sync",
             short_hits, long_hits, misses);
    if (mismatches == 0 && pending == 0) begin
      $display("ts_packet_sync_search: match");
    end else begin
      if (pending != 0) $display("%0d sync results never arrived", pending);
      $display("ts_packet_sync_search: mismatch");
    end
    $finish;
  end

endmodule

// ===== ts_packet_sync_search.f =====
hw/rtl/tsps_pkg.sv
hw/rtl/tsps_in_if.sv
hw/rtl/tsps_out_if.sv
hw/rtl/tsps_in_stage.sv
hw/rtl/tsps_sync_line.sv
hw/rtl/tsps_search_core.sv
hw/rtl/ts_packet_sync_search.sv
test/tsps_sync_checker.sv
test/tb_ts_packet_sync_search.sv
